### hw/rtl/gbim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbim_pkg: shared types and constants of the grid bisection index map
// Widths, division chain lengths, axis and region codes, and the structs
// that travel between the divider cells, the geometry unit and the output.
// ----------------------------------------------------------------------------
package gbim_pkg;

  localparam int MAX_EXTENT = 1024;
  localparam int DIM_W      = 11;
  localparam int IDX_W      = 30;
  localparam int COORD_W    = $clog2(MAX_EXTENT);
  localparam int Q1_W       = 2 * COORD_W;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int CFG_IDX_W  = 2;

  // x = i mod nx needs one cell per bit of i / nx, then one per bit of z
  localparam int N_CELLS_X  = Q1_W;
  localparam int N_CELLS_Y  = COORD_W;
  localparam int N_CELLS    = N_CELLS_X + N_CELLS_Y;
  // edges from the accepting edge to the edge that takes the result
  localparam int PIPE_DEPTH = N_CELLS + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    REGION_LEFT  = 2'd0,
    REGION_RIGHT = 2'd1,
    REGION_SEP   = 2'd2
  } region_t;

  // sideband that rides along the divider chain
  typedef struct packed {
    logic               bad;
    logic [COORD_W-1:0] x;
  } side_t;

  // grid geometry derived from the size registers
  typedef struct packed {
    axis_t              axis;
    logic [COORD_W-1:0] c;
    logic               bad;
    logic [DIM_W-1:0]   nz;
    logic [DIM_W-1:0]   d0_l;
    logic [DIM_W-1:0]   d0_r;
    logic [DIM_W-1:0]   d0_s;
    logic [PROD_W-1:0]  d01_l;
    logic [PROD_W-1:0]  d01_r;
    logic [PROD_W-1:0]  d01_s;
    logic [IDX_W-1:0]   off_r;
    logic [IDX_W-1:0]   off_s;
  } geom_t;

endpackage

### hw/rtl/gbim_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbim_div_cell: one restoring division step
// Shift in the next dividend bit, subtract the divisor when it fits and
// hand the partial remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module gbim_div_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [gbim_pkg::DIM_W-1:0]    rem_i,
  input  logic [gbim_pkg::Q1_W-1:0]     quo_i,
  input  gbim_pkg::side_t               side_i,
  input  logic [gbim_pkg::DIM_W-1:0]    divisor_i,
  output logic                          vld_o,
  output logic [gbim_pkg::DIM_W-1:0]    rem_o,
  output logic [gbim_pkg::Q1_W-1:0]     quo_o,
  output gbim_pkg::side_t               side_o
);

  logic [gbim_pkg::DIM_W:0]   trial;
  logic [gbim_pkg::DIM_W:0]   diff;
  logic                       fits;
  logic [gbim_pkg::DIM_W-1:0] rem_nxt;
  logic [gbim_pkg::Q1_W-1:0]  quo_nxt;

  logic                       vld_r;
  logic [gbim_pkg::DIM_W-1:0] rem_r;
  logic [gbim_pkg::Q1_W-1:0]  quo_r;
  gbim_pkg::side_t            side_r;

  always_comb begin
    trial   = {rem_i, quo_i[gbim_pkg::Q1_W-1]};
    diff    = trial - {1'b0, divisor_i};
    fits    = (trial >= {1'b0, divisor_i});
    rem_nxt = fits ? diff[gbim_pkg::DIM_W-1:0] : trial[gbim_pkg::DIM_W-1:0];
    quo_nxt = {quo_i[gbim_pkg::Q1_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

### hw/rtl/gbim_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbim_geom: grid geometry unit
// Pick the cut axis and plane from the size registers and derive the part
// strides and part offsets over three registered steps.
// ----------------------------------------------------------------------------
module gbim_geom (
  input  logic                        clk,
  input  logic [gbim_pkg::DIM_W-1:0]  size_x,
  input  logic [gbim_pkg::DIM_W-1:0]  size_y,
  input  logic [gbim_pkg::DIM_W-1:0]  size_z,
  output gbim_pkg::geom_t             geo
);

  localparam int OFF_W = gbim_pkg::DIM_W + gbim_pkg::PROD_W;

  // step 1: axis, cut plane, neighbor extents
  gbim_pkg::axis_t              axis;
  logic [gbim_pkg::DIM_W-1:0]   n;
  logic [gbim_pkg::DIM_W-1:0]   nm1;
  logic [gbim_pkg::COORD_W-1:0] c;
  logic [gbim_pkg::DIM_W-1:0]   cr;
  logic [gbim_pkg::DIM_W-1:0]   oa;
  logic [gbim_pkg::DIM_W-1:0]   ob;
  logic [gbim_pkg::DIM_W-1:0]   m;
  logic                         bad;

  gbim_pkg::axis_t              s1_axis_r;
  logic [gbim_pkg::COORD_W-1:0] s1_c_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_cr_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_nm1_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_oa_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_ob_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_m_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_nx_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_ny_r;
  logic [gbim_pkg::DIM_W-1:0]   s1_nz_r;
  logic                         s1_bad_r;

  // step 2: products of two extents
  logic [gbim_pkg::PROD_W-1:0]  other_nxt;
  logic [gbim_pkg::PROD_W-1:0]  wl_nxt;
  logic [gbim_pkg::PROD_W-1:0]  wr_nxt;

  gbim_pkg::axis_t              s2_axis_r;
  logic [gbim_pkg::COORD_W-1:0] s2_c_r;
  logic [gbim_pkg::DIM_W-1:0]   s2_cr_r;
  logic [gbim_pkg::DIM_W-1:0]   s2_nm1_r;
  logic [gbim_pkg::DIM_W-1:0]   s2_nx_r;
  logic [gbim_pkg::DIM_W-1:0]   s2_ny_r;
  logic [gbim_pkg::DIM_W-1:0]   s2_nz_r;
  logic                         s2_bad_r;
  logic [gbim_pkg::PROD_W-1:0]  s2_other_r;
  logic [gbim_pkg::PROD_W-1:0]  s2_wl_r;
  logic [gbim_pkg::PROD_W-1:0]  s2_wr_r;

  // step 3: offsets and per-part strides
  logic [OFF_W-1:0]             off_r_full;
  logic [OFF_W-1:0]             off_s_full;
  gbim_pkg::geom_t              geo_nxt;
  gbim_pkg::geom_t              geo_r;

  always_comb begin
    axis = gbim_pkg::AXIS_Z;
    n    = size_z;
    oa   = size_x;
    ob   = size_y;
    m    = size_x;
    if (size_x >= size_y && size_x >= size_z) begin
      axis = gbim_pkg::AXIS_X;
      n    = size_x;
      oa   = size_y;
      ob   = size_z;
      m    = size_y;
    end else if (size_y >= size_z) begin
      axis = gbim_pkg::AXIS_Y;
      n    = size_y;
      oa   = size_x;
      ob   = size_z;
      m    = size_x;
    end
    nm1 = n - gbim_pkg::DIM_W'(1);
    c   = nm1[gbim_pkg::DIM_W-1:1];
    cr  = nm1 - {1'b0, c};
    bad = (size_x == '0) || (size_y == '0) || (size_z == '0) ||
          (size_x > gbim_pkg::DIM_W'(gbim_pkg::MAX_EXTENT)) ||
          (size_y > gbim_pkg::DIM_W'(gbim_pkg::MAX_EXTENT)) ||
          (size_z > gbim_pkg::DIM_W'(gbim_pkg::MAX_EXTENT));
  end

  always_ff @(posedge clk) begin
    s1_axis_r <= axis;
    s1_c_r    <= c;
    s1_cr_r   <= cr;
    s1_nm1_r  <= nm1;
    s1_oa_r   <= oa;
    s1_ob_r   <= ob;
    s1_m_r    <= m;
    s1_nx_r   <= size_x;
    s1_ny_r   <= size_y;
    s1_nz_r   <= size_z;
    s1_bad_r  <= bad;
  end

  always_comb begin
    other_nxt = {{gbim_pkg::DIM_W{1'b0}}, s1_oa_r} * {{gbim_pkg::DIM_W{1'b0}}, s1_ob_r};
    wl_nxt    = {{(gbim_pkg::DIM_W + 1){1'b0}}, s1_c_r} * {{gbim_pkg::DIM_W{1'b0}}, s1_m_r};
    wr_nxt    = {{gbim_pkg::DIM_W{1'b0}}, s1_cr_r} * {{gbim_pkg::DIM_W{1'b0}}, s1_m_r};
  end

  always_ff @(posedge clk) begin
    s2_axis_r  <= s1_axis_r;
    s2_c_r     <= s1_c_r;
    s2_cr_r    <= s1_cr_r;
    s2_nm1_r   <= s1_nm1_r;
    s2_nx_r    <= s1_nx_r;
    s2_ny_r    <= s1_ny_r;
    s2_nz_r    <= s1_nz_r;
    s2_bad_r   <= s1_bad_r;
    s2_other_r <= other_nxt;
    s2_wl_r    <= wl_nxt;
    s2_wr_r    <= wr_nxt;
  end

  always_comb begin
    off_r_full = {{(gbim_pkg::PROD_W + 1){1'b0}}, s2_c_r} *
                 {{gbim_pkg::DIM_W{1'b0}}, s2_other_r};
    off_s_full = {{gbim_pkg::PROD_W{1'b0}}, s2_nm1_r} *
                 {{gbim_pkg::DIM_W{1'b0}}, s2_other_r};

    geo_nxt.axis  = s2_axis_r;
    geo_nxt.c     = s2_c_r;
    geo_nxt.bad   = s2_bad_r;
    geo_nxt.nz    = s2_nz_r;
    geo_nxt.off_r = off_r_full[gbim_pkg::IDX_W-1:0];
    geo_nxt.off_s = off_s_full[gbim_pkg::IDX_W-1:0];
    geo_nxt.d0_l  = s2_nx_r;
    geo_nxt.d0_r  = s2_nx_r;
    geo_nxt.d0_s  = s2_nx_r;
    geo_nxt.d01_l = s2_other_r;
    geo_nxt.d01_r = s2_other_r;
    geo_nxt.d01_s = s2_other_r;
    case (s2_axis_r)
      gbim_pkg::AXIS_X: begin
        // parts are w by ny by nz, the separator is one plane wide
        geo_nxt.d0_l  = {1'b0, s2_c_r};
        geo_nxt.d0_r  = s2_cr_r;
        geo_nxt.d0_s  = gbim_pkg::DIM_W'(1);
        geo_nxt.d01_l = s2_wl_r;
        geo_nxt.d01_r = s2_wr_r;
        geo_nxt.d01_s = {{gbim_pkg::DIM_W{1'b0}}, s2_ny_r};
      end
      gbim_pkg::AXIS_Y: begin
        geo_nxt.d01_l = s2_wl_r;
        geo_nxt.d01_r = s2_wr_r;
        geo_nxt.d01_s = {{gbim_pkg::DIM_W{1'b0}}, s2_nx_r};
      end
      default: begin
        // cut across z: strides stay nx and nx*ny in every part
      end
    endcase
  end

  always_ff @(posedge clk) begin
    geo_r <= geo_nxt;
  end

  assign geo = geo_r;

endmodule

### hw/rtl/gbim_assemble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbim_assemble: region select and index assembly
// Classify the point against the cut plane, form the in-part coordinates,
// multiply by the part strides and add the part offset.
// ----------------------------------------------------------------------------
module gbim_assemble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic                          bad_i,
  input  logic [gbim_pkg::COORD_W-1:0]  x_i,
  input  logic [gbim_pkg::COORD_W-1:0]  y_i,
  input  logic [gbim_pkg::COORD_W-1:0]  z_i,
  input  gbim_pkg::geom_t               geo_i,
  output logic                          out_valid_o,
  output logic [gbim_pkg::IDX_W-1:0]    new_index_o,
  output logic [1:0]                    region_o,
  output logic                          invalid_o
);

  localparam int P1_W = gbim_pkg::COORD_W + gbim_pkg::DIM_W;
  localparam int P2_W = gbim_pkg::COORD_W + gbim_pkg::PROD_W;

  logic [gbim_pkg::COORD_W-1:0] u;
  logic [gbim_pkg::COORD_W-1:0] u_p;
  gbim_pkg::region_t            region;
  logic [gbim_pkg::COORD_W-1:0] a0;
  logic [gbim_pkg::COORD_W-1:0] a1;
  logic [gbim_pkg::COORD_W-1:0] a2;
  logic [gbim_pkg::DIM_W-1:0]   d0;
  logic [gbim_pkg::PROD_W-1:0]  d01;
  logic [gbim_pkg::IDX_W-1:0]   off;
  logic                         inv;

  logic                         e1_vld_r;
  logic                         e1_inv_r;
  gbim_pkg::region_t            e1_region_r;
  logic [gbim_pkg::COORD_W-1:0] e1_a0_r;
  logic [gbim_pkg::COORD_W-1:0] e1_a1_r;
  logic [gbim_pkg::COORD_W-1:0] e1_a2_r;
  logic [gbim_pkg::DIM_W-1:0]   e1_d0_r;
  logic [gbim_pkg::PROD_W-1:0]  e1_d01_r;
  logic [gbim_pkg::IDX_W-1:0]   e1_off_r;

  logic [P1_W-1:0]              p1;
  logic [P2_W-1:0]              p2;
  logic [gbim_pkg::IDX_W-1:0]   s0;

  logic                         e2_vld_r;
  logic                         e2_inv_r;
  gbim_pkg::region_t            e2_region_r;
  logic [P1_W-1:0]              e2_p1_r;
  logic [gbim_pkg::IDX_W-1:0]   e2_p2_r;
  logic [gbim_pkg::IDX_W-1:0]   e2_s0_r;

  logic [gbim_pkg::IDX_W-1:0]   sum;

  logic                         out_valid_r;
  logic [gbim_pkg::IDX_W-1:0]   out_index_r;
  gbim_pkg::region_t            out_region_r;
  logic                         out_invalid_r;

  always_comb begin
    case (geo_i.axis)
      gbim_pkg::AXIS_X: u = x_i;
      gbim_pkg::AXIS_Y: u = y_i;
      default:          u = z_i;
    endcase

    if (u < geo_i.c) begin
      region = gbim_pkg::REGION_LEFT;
      u_p    = u;
    end else if (u > geo_i.c) begin
      region = gbim_pkg::REGION_RIGHT;
      u_p    = u - geo_i.c - gbim_pkg::COORD_W'(1);
    end else begin
      region = gbim_pkg::REGION_SEP;
      u_p    = '0;
    end

    a0 = x_i;
    a1 = y_i;
    a2 = z_i;
    case (geo_i.axis)
      gbim_pkg::AXIS_X: a0 = u_p;
      gbim_pkg::AXIS_Y: a1 = u_p;
      default:          a2 = u_p;
    endcase

    case (region)
      gbim_pkg::REGION_LEFT: begin
        d0  = geo_i.d0_l;
        d01 = geo_i.d01_l;
        off = '0;
      end
      gbim_pkg::REGION_RIGHT: begin
        d0  = geo_i.d0_r;
        d01 = geo_i.d01_r;
        off = geo_i.off_r;
      end
      default: begin
        d0  = geo_i.d0_s;
        d01 = geo_i.d01_s;
        off = geo_i.off_s;
      end
    endcase

    // z beyond the grid covers every index past the last point
    inv = bad_i || geo_i.bad || ({1'b0, z_i} >= geo_i.nz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r    <= 1'b0;
      e2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e1_vld_r    <= vld_i;
      e2_vld_r    <= e1_vld_r;
      out_valid_r <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_inv_r    <= inv;
    e1_region_r <= region;
    e1_a0_r     <= a0;
    e1_a1_r     <= a1;
    e1_a2_r     <= a2;
    e1_d0_r     <= d0;
    e1_d01_r    <= d01;
    e1_off_r    <= off;
  end

  always_comb begin
    p1 = {{gbim_pkg::DIM_W{1'b0}}, e1_a1_r} * {{gbim_pkg::COORD_W{1'b0}}, e1_d0_r};
    p2 = {{gbim_pkg::PROD_W{1'b0}}, e1_a2_r} * {{gbim_pkg::COORD_W{1'b0}}, e1_d01_r};
    s0 = e1_off_r + {{(gbim_pkg::IDX_W - gbim_pkg::COORD_W){1'b0}}, e1_a0_r};
  end

  always_ff @(posedge clk) begin
    e2_inv_r    <= e1_inv_r;
    e2_region_r <= e1_region_r;
    e2_p1_r     <= p1;
    e2_p2_r     <= p2[gbim_pkg::IDX_W-1:0];
    e2_s0_r     <= s0;
  end

  always_comb begin
    sum = e2_s0_r + {{(gbim_pkg::IDX_W - P1_W){1'b0}}, e2_p1_r} + e2_p2_r;
  end

  // drop index and region of an invalid request to zero
  always_ff @(posedge clk) begin
    out_invalid_r <= e2_inv_r;
    out_index_r   <= e2_inv_r ? '0 : sum;
    out_region_r  <= e2_inv_r ? gbim_pkg::REGION_LEFT : e2_region_r;
  end

  assign out_valid_o = out_valid_r;
  assign new_index_o = out_index_r;
  assign region_o    = out_region_r;
  assign invalid_o   = out_invalid_r;

endmodule

### hw/rtl/grid_bisection_index_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bisection_index_map_top: one-level bisection ordering of a 3-D grid
// Maps the linear index of a grid point to its position when the grid is cut
// across its largest extent: left part, right part, separator plane last.
// ----------------------------------------------------------------------------
// Use:
//   Request word: drive in_point_index and raise start; the word is taken at
//   every rising edge with start high and busy low. busy is low whenever the
//   block is out of reset, so one word can be taken in every cycle.
//   Result word: out_valid strobes for one cycle with out_new_index,
//   out_region (0 left, 1 right, 2 separator) and out_invalid. Results leave
//   in request order. The receiver cannot stall the block; it must take each
//   word in the cycle it is shown.
//   Pipeline: the accepting edge loads the word into a chain of 30 divider
//   cells (one quotient bit per cell) that splits the index into x, y and z;
//   three assembly stages follow, the last of which drives the strobe.
//   Throughput is one word per cycle, since every cell hands its word on
//   at each edge.
//   Configuration: cfg_we writes cfg_wdata into size_x, size_y or size_z by
//   cfg_index at the edge; write only while no request is in flight.
//   Reset (rst_n low, synchronous): sizes return to 1 and all words in flight
//   are dropped; busy is high while reset is held. The derived geometry
//   follows a write or reset through the registered steps of gbim_geom.
// ----------------------------------------------------------------------------
module grid_bisection_index_map_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gbim_pkg::IDX_W-1:0]        in_point_index,
  output logic                              out_valid,
  output logic [gbim_pkg::IDX_W-1:0]        out_new_index,
  output logic [1:0]                        out_region,
  output logic                              out_invalid,
  input  logic                              cfg_we,
  input  logic [gbim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbim_pkg::DIM_W-1:0]        cfg_wdata
);

  localparam int NX = gbim_pkg::N_CELLS_X;
  localparam int NC = gbim_pkg::N_CELLS;
  localparam int CW = gbim_pkg::COORD_W;
  localparam int QW = gbim_pkg::Q1_W;
  localparam int IW = gbim_pkg::IDX_W;

  // size registers
  logic [gbim_pkg::DIM_W-1:0] size_x_r;
  logic [gbim_pkg::DIM_W-1:0] size_y_r;
  logic [gbim_pkg::DIM_W-1:0] size_z_r;

  // chain taps: cell k drives entry k
  logic                       cell_vld [NC];
  logic [gbim_pkg::DIM_W-1:0] cell_rem [NC];
  logic [QW-1:0]              cell_quo [NC];
  gbim_pkg::side_t            cell_side[NC];

  // chain entry and the hand-over from the x divider to the y divider
  logic                       head_vld;
  logic [gbim_pkg::DIM_W-1:0] head_rem;
  logic [QW-1:0]              head_quo;
  gbim_pkg::side_t            head_side;
  logic [QW-1:0]              q1;
  logic [gbim_pkg::DIM_W-1:0] join_rem;
  logic [QW-1:0]              join_quo;
  gbim_pkg::side_t            join_side;

  gbim_pkg::geom_t            geo;

  // hold off requests while reset is asserted
  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= gbim_pkg::DIM_W'(1);
      size_y_r <= gbim_pkg::DIM_W'(1);
      size_z_r <= gbim_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbim_pkg::CFG_SIZE_X: size_x_r <= cfg_wdata;
        gbim_pkg::CFG_SIZE_Y: size_y_r <= cfg_wdata;
        gbim_pkg::CFG_SIZE_Z: size_z_r <= cfg_wdata;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  gbim_geom u_geom (
    .clk    (clk),
    .size_x (size_x_r),
    .size_y (size_y_r),
    .size_z (size_z_r),
    .geo    (geo)
  );

  // First divider: i / nx. Any valid index has i / nx below 2**QW, so the
  // top CW bits start as the partial remainder; if they already reach nx the
  // index lies past the grid and the word is flagged bad.
  always_comb begin
    head_vld       = start & ~busy;
    head_rem       = {1'b0, in_point_index[IW-1:QW]};
    head_quo       = in_point_index[QW-1:0];
    head_side.bad  = ({1'b0, in_point_index[IW-1:QW]} >= size_x_r);
    head_side.x    = '0;
  end

  // Second divider: (i / nx) / ny. The quotient goes in through the upper
  // CW bits of the shift word; its top CW bits start the remainder, with the
  // same overflow check against ny. x is the first remainder.
  always_comb begin
    q1             = cell_quo[NX-1];
    join_rem       = {1'b0, q1[QW-1:CW]};
    join_quo       = {q1[CW-1:0], {(QW - CW){1'b0}}};
    join_side.bad  = cell_side[NX-1].bad || ({1'b0, q1[QW-1:CW]} >= size_y_r);
    join_side.x    = cell_rem[NX-1][CW-1:0];
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic                       vld_in;
    logic [gbim_pkg::DIM_W-1:0] rem_in;
    logic [QW-1:0]              quo_in;
    gbim_pkg::side_t            side_in;
    logic [gbim_pkg::DIM_W-1:0] divisor;

    if (k == 0) begin : g_head
      assign vld_in  = head_vld;
      assign rem_in  = head_rem;
      assign quo_in  = head_quo;
      assign side_in = head_side;
    end else if (k == NX) begin : g_join
      assign vld_in  = cell_vld[k-1];
      assign rem_in  = join_rem;
      assign quo_in  = join_quo;
      assign side_in = join_side;
    end else begin : g_link
      assign vld_in  = cell_vld[k-1];
      assign rem_in  = cell_rem[k-1];
      assign quo_in  = cell_quo[k-1];
      assign side_in = cell_side[k-1];
    end

    if (k < NX) begin : g_div_x
      assign divisor = size_x_r;
    end else begin : g_div_y
      assign divisor = size_y_r;
    end

    gbim_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .vld_i     (vld_in),
      .rem_i     (rem_in),
      .quo_i     (quo_in),
      .side_i    (side_in),
      .divisor_i (divisor),
      .vld_o     (cell_vld[k]),
      .rem_o     (cell_rem[k]),
      .quo_o     (cell_quo[k]),
      .side_o    (cell_side[k])
    );
  end

  // chain tail: remainder is y, low quotient bits are z
  gbim_assemble u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (cell_vld[NC-1]),
    .bad_i       (cell_side[NC-1].bad),
    .x_i         (cell_side[NC-1].x),
    .y_i         (cell_rem[NC-1][CW-1:0]),
    .z_i         (cell_quo[NC-1][CW-1:0]),
    .geo_i       (geo),
    .out_valid_o (out_valid),
    .new_index_o (out_new_index),
    .region_o    (out_region),
    .invalid_o   (out_invalid)
  );

endmodule

### hw/rtl/gbim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbim_checker: port-level checks of the grid bisection index map
// Watch the request and result ports and flag words that appear without a
// request, malformed results and requests taken during reset.
// ----------------------------------------------------------------------------
module gbim_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          out_valid,
  input  logic [gbim_pkg::IDX_W-1:0]    out_new_index,
  input  logic [1:0]                    out_region,
  input  logic                          out_invalid
);

  // every result word traces back to a request a fixed latency earlier
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, gbim_pkg::PIPE_DEPTH))
    else $error("result word without a matching request");

  // an invalid result carries zero index and zero region
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |->
      (out_new_index == '0 && out_region == gbim_pkg::REGION_LEFT))
    else $error("invalid result with nonzero payload");

  // region code is left, right or separator
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region == gbim_pkg::REGION_LEFT ||
                   out_region == gbim_pkg::REGION_RIGHT ||
                   out_region == gbim_pkg::REGION_SEP))
    else $error("result region code out of range");

  // no request can be taken while reset is held
  a_busy_in_reset: assert property (@(posedge clk)
    !rst_n |-> busy)
    else $error("busy low during reset");

endmodule

bind grid_bisection_index_map_top gbim_checker u_gbim_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_new_index (out_new_index),
  .out_region    (out_region),
  .out_invalid   (out_invalid)
);
